// ===== design/scd_pkg.sv =====
package scd_pkg;

  localparam int LineLen      = 66;
  localparam int DataLen      = 64;
  localparam int CsumPos      = 64;
  localparam int MaxValuesDef = 1024;

  localparam logic [7:0] CharBias    = 8'd48;
  localparam logic [2:0] DigitsReset = 3'd3;

  // one decoded result, moved from the decoder to the output register
  typedef struct packed {
    logic        value_valid;
    logic [23:0] value;
    logic [9:0]  value_index;
    logic        checksum_valid;
    logic        checksum_ok;
    logic [10:0] values_so_far;
  } result_t;

  // clamp the digit count register to 1..4
  function automatic logic [2:0] effective_digits(input logic [2:0] dpv);
    logic [2:0] d;
    d = dpv;
    if (dpv == 3'd0) begin
      d = 3'd1;
    end else if (dpv > 3'd4) begin
      d = 3'd4;
    end
    return d;
  endfunction

endpackage

// ===== design/scd_decode.sv =====
module scd_decode
  import scd_pkg::*;
#(
  parameter int MAX_VALUES = MaxValuesDef
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          step,
  input  logic          start_of_block,
  input  logic [7:0]    character,
  input  logic [2:0]    digits_per_value,
  output result_t       res
);

  logic [6:0]  line_position, line_position_next;
  logic [1:0]  digit_count, digit_count_next;
  logic [23:0] value_accumulator, value_accumulator_next;
  logic [10:0] stored_count, stored_count_next;
  logic [5:0]  line_sum, line_sum_next;

  logic [6:0]  pos;
  logic [1:0]  cnt;
  logic [23:0] acc;
  logic [10:0] stored;
  logic [5:0]  lsum;
  logic [5:0]  digit;
  logic [23:0] acc_shift;
  logic [7:0]  csum_char;

  always_comb begin
    // a start of block clears everything before this character is handled
    pos    = start_of_block ? 7'd0 : line_position;
    cnt    = start_of_block ? 2'd0 : digit_count;
    acc    = start_of_block ? 24'd0 : value_accumulator;
    stored = start_of_block ? 11'd0 : stored_count;
    lsum   = start_of_block ? 6'd0 : line_sum;

    digit     = 6'(character - CharBias);
    acc_shift = {acc[17:0], digit};
    csum_char = {2'b00, lsum} + CharBias;

    line_position_next     = (pos == 7'(LineLen - 1)) ? 7'd0 : pos + 7'd1;
    digit_count_next       = cnt;
    value_accumulator_next = acc;
    stored_count_next      = stored;
    line_sum_next          = lsum;

    res.value_valid    = 1'b0;
    res.value          = '0;
    res.value_index    = '0;
    res.checksum_valid = 1'b0;
    res.checksum_ok    = 1'b0;

    if (pos < 7'(DataLen)) begin
      line_sum_next = lsum + character[5:0];
      if ({1'b0, cnt} + 3'd1 >= effective_digits(digits_per_value)) begin
        if (stored < 11'(MAX_VALUES)) begin
          res.value_valid   = 1'b1;
          res.value         = acc_shift;
          res.value_index   = stored[9:0];
          stored_count_next = stored + 11'd1;
        end
        value_accumulator_next = '0;
        digit_count_next       = 2'd0;
      end else begin
        value_accumulator_next = acc_shift;
        digit_count_next       = cnt + 2'd1;
      end
    end else if (pos == 7'(CsumPos)) begin
      res.checksum_valid = 1'b1;
      res.checksum_ok    = (csum_char == character);
      line_sum_next      = 6'd0;
    end

    res.values_so_far = stored_count_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_position     <= '0;
      digit_count       <= '0;
      value_accumulator <= '0;
      stored_count      <= '0;
      line_sum          <= '0;
    end else if (step) begin
      line_position     <= line_position_next;
      digit_count       <= digit_count_next;
      value_accumulator <= value_accumulator_next;
      stored_count      <= stored_count_next;
      line_sum          <= line_sum_next;
    end
  end

endmodule

// ===== design/scan_line_char_decoder.sv =====
// channel   | direction | handshake          | payload
// ----------+-----------+--------------------+-----------------------------------------
// s_        | in        | s_tvalid/s_tready  | s_tuser: start_of_block, s_tdata: character
// m_        | out       | m_tvalid/m_tready  | m_tuser: flags, m_tdata: value, index, count
// cfg_      | in        | cfg_valid/cfg_ready| cfg_data: digits_per_value
//
// one character per cycle sustained while m_ is not stalled; a character accepted on s_
// passes through the input register, then is decoded into the result register
// rst is synchronous, active high; it clears the line state, the count of stored
// values and both pipeline valids, and sets digits_per_value back to 3
// a stall on m_tready holds the result register and backs up into the input
// register; s_tready drops only when both registers are full and m_ is stalled
module scan_line_char_decoder
  import scd_pkg::*;
#(
  parameter int MAX_VALUES = MaxValuesDef
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] character
  input  logic        s_tuser,   // [0] start_of_block
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // [23:0] value, [33:24] value_index, [44:34] values_so_far
  output logic [2:0]  m_tuser,   // [0] value_valid, [1] checksum_valid, [2] checksum_ok
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_data   // [2:0] digits_per_value
);

  // config register, always writable
  logic [2:0] digits_per_value;

  // input register
  logic       in_valid;
  logic       in_sob;
  logic [7:0] in_char;

  // result register
  logic       out_valid;
  result_t    out_res;
  result_t    dec_res;

  logic advance;
  logic step;

  assign cfg_ready = 1'b1;

  // the result register can take a new result when empty or being drained
  assign advance  = !out_valid || m_tready;
  assign s_tready = !in_valid || advance;
  assign step     = in_valid && advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      digits_per_value <= DigitsReset;
    end else if (cfg_valid && cfg_ready) begin
      digits_per_value <= cfg_data;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_sob  <= s_tuser;
      in_char <= s_tdata;
    end
  end

  // decode logic plus line and block state, advanced once per character
  scd_decode #(
    .MAX_VALUES(MAX_VALUES)
  ) u_decode (
    .clk             (clk),
    .rst             (rst),
    .step            (step),
    .start_of_block  (in_sob),
    .character       (in_char),
    .digits_per_value(digits_per_value),
    .res             (dec_res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_res <= dec_res;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {3'b000, out_res.values_so_far, out_res.value_index, out_res.value};
  assign m_tuser  = {out_res.checksum_ok, out_res.checksum_valid, out_res.value_valid};

endmodule
